>>> rtl/scf_pkg.sv
// Shared types, command codes and constants of the stepper CAN command framer.
package scf_pkg;

    localparam int MAX_PAYLOAD_DEF = 7;
    localparam int CMD_BYTES       = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ADDR   = 2'd0;
    localparam logic [1:0] CFG_CHECK  = 2'd1;
    localparam logic [1:0] CFG_MAXSPD = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0]  ADDR_RST   = 8'd1;
    localparam logic [7:0]  CHECK_RST  = 8'd107;
    localparam logic [15:0] MAXSPD_RST = 16'd5000;

    // Command selection codes on the input.
    typedef enum logic [3:0] {
        FN_ENABLE      = 4'd0,
        FN_SPEED       = 4'd1,
        FN_POSITION    = 4'd2,
        FN_QUICK_SETUP = 4'd3,
        FN_QUICK_MOVE  = 4'd4,
        FN_STOP        = 4'd5,
        FN_HOME        = 4'd6,
        FN_ABORT_HOME  = 4'd7,
        FN_ORIGIN      = 4'd8,
        FN_ZERO        = 4'd9,
        FN_CLEAR_FAULT = 4'd10,
        FN_SYNC        = 4'd11,
        FN_READ_PARAM  = 4'd12,
        FN_AUTO_RETURN = 4'd13
    } t_func;

    // Bytes sent on the bus.
    localparam logic [7:0] OP_ENABLE      = 8'hF3;
    localparam logic [7:0] OP_SPEED       = 8'hF6;
    localparam logic [7:0] OP_POSITION    = 8'hFD;
    localparam logic [7:0] OP_QUICK_SETUP = 8'hF1;
    localparam logic [7:0] OP_QUICK_MOVE  = 8'hFC;
    localparam logic [7:0] OP_STOP        = 8'hFE;
    localparam logic [7:0] OP_HOME        = 8'h9A;
    localparam logic [7:0] OP_ABORT_HOME  = 8'h9C;
    localparam logic [7:0] OP_ORIGIN      = 8'h93;
    localparam logic [7:0] OP_ZERO        = 8'h0A;
    localparam logic [7:0] OP_CLEAR_FAULT = 8'h0E;
    localparam logic [7:0] OP_SYNC        = 8'hFF;
    localparam logic [7:0] OP_AUTO_RETURN = 8'h11;

    localparam logic [7:0] SUB_ENABLE      = 8'hAB;
    localparam logic [7:0] SUB_STOP        = 8'h98;
    localparam logic [7:0] SUB_ABORT_HOME  = 8'h48;
    localparam logic [7:0] SUB_ORIGIN      = 8'h88;
    localparam logic [7:0] SUB_ZERO        = 8'h6D;
    localparam logic [7:0] SUB_CLEAR_FAULT = 8'h52;
    localparam logic [7:0] SUB_SYNC        = 8'h66;
    localparam logic [7:0] SUB_AUTO_RETURN = 8'h18;

    localparam logic [7:0] POS_MODE_MAX  = 8'd2;
    localparam logic [7:0] HOME_MODE_MAX = 8'd3;

    // One built command, checksum included, waiting to be cut into frames.
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [3:0]                len;
        logic [7:0]                addr;
        logic                      rejected;
    } t_cmd;

endpackage

>>> rtl/scf_cmd_build.sv
// Command byte builder with the command holding register.
module scf_cmd_build (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_done,
    input  logic [7:0]           i_addr,
    input  logic [7:0]           i_check,
    input  logic [15:0]          i_max_speed,
    input  logic [3:0]           i_func,
    input  logic                 i_enable_flag,
    input  logic                 i_sync_flag,
    input  logic [15:0]          i_speed_rpm,
    input  logic                 i_reverse,
    input  logic [7:0]           i_acceleration,
    input  logic signed [31:0]   i_pulse_count,
    input  logic [7:0]           i_mode_code,
    input  logic [7:0]           i_parameter_code,
    input  logic [15:0]          i_period_ms,
    output logic                 o_valid,
    output scf_pkg::t_cmd        o_cmd
);
    import scf_pkg::*;

    logic        r_valid;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic        n_valid;
    logic [15:0] spd;
    logic [31:0] pul;
    logic [31:0] mag;
    logic [7:0]  en_b;
    logic [7:0]  sy_b;

    assign spd  = (i_speed_rpm > i_max_speed) ? i_max_speed : i_speed_rpm;
    assign pul  = i_pulse_count;
    assign mag  = pul[31] ? (32'd0 - pul) : pul;
    assign en_b = {7'd0, i_enable_flag};
    assign sy_b = {7'd0, i_sync_flag};

    always_comb begin
        n_cmd          = '0;
        n_cmd.addr     = i_addr;
        n_cmd.rejected = 1'b0;
        unique case (t_func'(i_func))
            FN_ENABLE: begin
                n_cmd.bytes[3:0] = {sy_b, en_b, SUB_ENABLE, OP_ENABLE};
                n_cmd.len        = 4'd4;
            end
            FN_SPEED: begin
                n_cmd.bytes[5:0] = {sy_b, i_acceleration, spd[7:0], spd[15:8],
                                    7'd0, i_reverse, OP_SPEED};
                n_cmd.len        = 4'd6;
            end
            FN_POSITION: begin
                if (i_mode_code > POS_MODE_MAX) begin
                    n_cmd.rejected = 1'b1;
                end else begin
                    n_cmd.bytes[10:0] = {sy_b, i_mode_code, mag[7:0], mag[15:8],
                                         mag[23:16], mag[31:24], i_acceleration,
                                         spd[7:0], spd[15:8], 7'd0, pul[31],
                                         OP_POSITION};
                    n_cmd.len         = 4'd11;
                end
            end
            FN_QUICK_SETUP: begin
                if (i_mode_code > POS_MODE_MAX) begin
                    n_cmd.rejected = 1'b1;
                end else begin
                    n_cmd.bytes[5:0] = {sy_b, i_mode_code, i_acceleration, spd[7:0],
                                        spd[15:8], OP_QUICK_SETUP};
                    n_cmd.len        = 4'd6;
                end
            end
            FN_QUICK_MOVE: begin
                n_cmd.bytes[4:0] = {pul[7:0], pul[15:8], pul[23:16], pul[31:24],
                                    OP_QUICK_MOVE};
                n_cmd.len        = 4'd5;
            end
            FN_STOP: begin
                n_cmd.bytes[2:0] = {sy_b, SUB_STOP, OP_STOP};
                n_cmd.len        = 4'd3;
            end
            FN_HOME: begin
                if (i_mode_code > HOME_MODE_MAX) begin
                    n_cmd.rejected = 1'b1;
                end else begin
                    n_cmd.bytes[2:0] = {sy_b, i_mode_code, OP_HOME};
                    n_cmd.len        = 4'd3;
                end
            end
            FN_ABORT_HOME: begin
                n_cmd.bytes[1:0] = {SUB_ABORT_HOME, OP_ABORT_HOME};
                n_cmd.len        = 4'd2;
            end
            FN_ORIGIN: begin
                n_cmd.bytes[2:0] = {en_b, SUB_ORIGIN, OP_ORIGIN};
                n_cmd.len        = 4'd3;
            end
            FN_ZERO: begin
                n_cmd.bytes[1:0] = {SUB_ZERO, OP_ZERO};
                n_cmd.len        = 4'd2;
            end
            FN_CLEAR_FAULT: begin
                n_cmd.bytes[1:0] = {SUB_CLEAR_FAULT, OP_CLEAR_FAULT};
                n_cmd.len        = 4'd2;
            end
            FN_SYNC: begin
                n_cmd.bytes[1:0] = {SUB_SYNC, OP_SYNC};
                n_cmd.len        = 4'd2;
                n_cmd.addr       = 8'd0;
            end
            FN_READ_PARAM: begin
                n_cmd.bytes[0] = i_parameter_code;
                n_cmd.len      = 4'd1;
            end
            FN_AUTO_RETURN: begin
                n_cmd.bytes[4:0] = {i_period_ms[7:0], i_period_ms[15:8],
                                    i_parameter_code, SUB_AUTO_RETURN, OP_AUTO_RETURN};
                n_cmd.len        = 4'd5;
            end
            default: begin
                n_cmd.rejected = 1'b1;
            end
        endcase
        // Unless the command is rejected, the check byte follows the last argument byte.
        if (!n_cmd.rejected) begin
            n_cmd.bytes[n_cmd.len] = i_check;
            n_cmd.len              = n_cmd.len + 4'd1;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_done) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

>>> rtl/scf_frame_out.sv
// Frame cutter: one CAN frame per cycle from the held command into the result register.
module scf_frame_out #(
    parameter int MAX_PAYLOAD = scf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  scf_pkg::t_cmd  i_cmd,
    output logic           o_done,
    output logic           o_valid,
    output logic [15:0]    o_can_id,
    output logic [3:0]     o_frame_length,
    output logic [31:0]    o_bytes_low,
    output logic [31:0]    o_bytes_high,
    output logic           o_rejected,
    output logic           o_last_frame
);
    import scf_pkg::*;

    localparam logic [4:0] MP = 5'(MAX_PAYLOAD);

    logic            r_k;
    logic            r_valid;
    logic [15:0]     r_can_id;
    logic [3:0]      r_len;
    logic [7:0][7:0] r_fb;
    logic            r_rej;
    logic            r_last;

    logic [4:0]      off;
    logic [4:0]      rem;
    logic [4:0]      pl;
    logic [4:0]      end_pos;
    logic            last;
    logic [7:0][7:0] fb;
    logic [4:0]      src;

    assign off     = r_k ? (5'd1 + MP) : 5'd1;
    assign rem     = {1'b0, i_cmd.len} - off;
    assign pl      = (rem > MP) ? MP : rem;
    assign end_pos = off + pl;
    assign last    = i_cmd.rejected || r_k || (end_pos >= {1'b0, i_cmd.len});
    assign o_done  = i_cmd_valid && last;

    always_comb begin
        fb    = '0;
        src   = '0;
        fb[0] = i_cmd.bytes[0];
        for (int i = 0; i < 7; i++) begin
            src = off + 5'(i);
            if (5'(i) < pl) begin
                fb[i + 1] = i_cmd.bytes[src[3:0]];
            end
        end
        if (i_cmd.rejected) begin
            fb = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd_valid;
            if (i_cmd_valid) begin
                r_k <= !last;
            end
        end
        if (i_cmd_valid) begin
            r_can_id <= i_cmd.rejected ? 16'd0 : {i_cmd.addr, 7'd0, r_k};
            r_len    <= i_cmd.rejected ? 4'd0 : 4'(pl + 5'd1);
            r_fb     <= fb;
            r_rej    <= i_cmd.rejected;
            r_last   <= last;
        end
    end

    assign o_valid        = r_valid;
    assign o_can_id       = r_can_id;
    assign o_frame_length = r_len;
    assign o_bytes_low    = r_fb[3:0];
    assign o_bytes_high   = r_fb[7:4];
    assign o_rejected     = r_rej;
    assign o_last_frame   = r_last;

    // The second frame is only ever cut while its command is still held.
    a_k_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k |-> i_cmd_valid)
        else $error("second frame pending without a held command");

    // The second frame of a command always closes it.
    a_second_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k |=> (o_valid && o_last_frame))
        else $error("second frame not marked last");

    // A rejected command is a single empty word.
    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> (o_last_frame && o_frame_length == 4'd0))
        else $error("rejected word malformed");

endmodule

>>> rtl/stepper_can_command_framer.sv
// Top level of the stepper CAN command framer: configuration registers and the two stages.
//
// A command is taken when i_start is high and o_busy is low. The command bytes, with the
// check byte appended, are built from the inputs and the current configuration and held in
// one register; from there one CAN frame a cycle is cut into the result register and shown
// for exactly one cycle with o_valid high. The receiver cannot stall, so every word must be
// taken in the cycle it appears. A command leaves one or two frames (a rejected mode gives a
// single word with o_rejected set); o_busy is high only while the cutter still owes the
// second frame of the held command, and a new command is taken in the same cycle the last
// frame is cut. A taken command passes the holding register and then the result register
// before its first word is on the result ports. Configuration writes are always ready;
// write them only while no command is in flight.
module stepper_can_command_framer #(
    parameter int MAX_PAYLOAD = scf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command side
    input  logic                i_start,
    output logic                o_busy,
    input  logic [3:0]          i_func,
    input  logic                i_enable_flag,
    input  logic                i_sync_flag,
    input  logic [15:0]         i_speed_rpm,
    input  logic                i_reverse,
    input  logic [7:0]          i_acceleration,
    input  logic signed [31:0]  i_pulse_count,
    input  logic [7:0]          i_mode_code,
    input  logic [7:0]          i_parameter_code,
    input  logic [15:0]         i_period_ms,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    // result side
    output logic                o_valid,
    output logic [15:0]         o_can_id,
    output logic [3:0]          o_frame_length,
    output logic [31:0]         o_bytes_low,
    output logic [31:0]         o_bytes_high,
    output logic                o_rejected,
    output logic                o_last_frame
);
    import scf_pkg::*;

    logic [7:0]  r_addr;
    logic [7:0]  r_check;
    logic [15:0] r_maxspd;

    logic        load;
    logic        done;
    logic        cmd_valid;
    t_cmd        cmd;

    // Configuration registers: a write to an unused index is taken and dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= ADDR_RST;
            r_check  <= CHECK_RST;
            r_maxspd <= MAXSPD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ADDR:   r_addr   <= i_cfg_data[7:0];
                CFG_CHECK:  r_check  <= i_cfg_data[7:0];
                CFG_MAXSPD: r_maxspd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The held command is busy unless the frame cut this cycle is its last.
    assign o_busy = cmd_valid && !done;
    assign load   = i_start && !o_busy;

    scf_cmd_build u_build (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (load),
        .i_done           (done),
        .i_addr           (r_addr),
        .i_check          (r_check),
        .i_max_speed      (r_maxspd),
        .i_func           (i_func),
        .i_enable_flag    (i_enable_flag),
        .i_sync_flag      (i_sync_flag),
        .i_speed_rpm      (i_speed_rpm),
        .i_reverse        (i_reverse),
        .i_acceleration   (i_acceleration),
        .i_pulse_count    (i_pulse_count),
        .i_mode_code      (i_mode_code),
        .i_parameter_code (i_parameter_code),
        .i_period_ms      (i_period_ms),
        .o_valid          (cmd_valid),
        .o_cmd            (cmd)
    );

    scf_frame_out #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_done         (done),
        .o_valid        (o_valid),
        .o_can_id       (o_can_id),
        .o_frame_length (o_frame_length),
        .o_bytes_low    (o_bytes_low),
        .o_bytes_high   (o_bytes_high),
        .o_rejected     (o_rejected),
        .o_last_frame   (o_last_frame)
    );

    // An accepted command brings its first word out after the holding and result registers.
    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("accepted command produced no word");

endmodule

>>> bench/tb.sv
// Self-checking testbench for the stepper CAN command framer.
`timescale 1ns / 100ps

module tb;
    import scf_pkg::*;

    // Function codes the block does not define; both must come back rejected.
    localparam logic [3:0] FN_RESERVED_LO = 4'd14;
    localparam logic [3:0] FN_RESERVED_HI = 4'd15;

    // Payload bytes per frame of the instance below (it keeps the default).
    localparam int unsigned FRAME_PAYLOAD = MAX_PAYLOAD_DEF;
    // Frames that one command may produce at most.
    localparam int unsigned FRAME_CAP = 2;

    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 125;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int SETTLE_CYCLES   = 8;

    // One command as it goes into the block.
    typedef struct packed {
        logic [3:0]  func;
        logic        en;
        logic        sy;
        logic [15:0] spd;
        logic        rev;
        logic [7:0]  acc;
        logic [31:0] pul;
        logic [7:0]  mode;
        logic [7:0]  par;
        logic [15:0] per;
    } command_t;

    // One CAN frame as it leaves the block.
    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  len;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        rej;
        logic        last;
    } frame_t;

    // A row of the directed table. Where golden is set, want is the frame typed in by
    // hand and replaces the prediction; such rows are all single-frame commands.
    typedef struct packed {
        command_t cmd;
        logic     golden;
        frame_t   want;
    } directed_row_t;

    localparam frame_t REJECT_FRAME = '{16'h0000, 4'd0, 32'h0, 32'h0, 1'b1, 1'b1};
    localparam frame_t NO_FRAME     = '0;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [3:0]          i_func;
    logic                i_enable_flag;
    logic                i_sync_flag;
    logic [15:0]         i_speed_rpm;
    logic                i_reverse;
    logic [7:0]          i_acceleration;
    logic signed [31:0]  i_pulse_count;
    logic [7:0]          i_mode_code;
    logic [7:0]          i_parameter_code;
    logic [15:0]         i_period_ms;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [15:0]         i_cfg_data;
    logic                o_valid;
    logic [15:0]         o_can_id;
    logic [3:0]          o_frame_length;
    logic [31:0]         o_bytes_low;
    logic [31:0]         o_bytes_high;
    logic                o_rejected;
    logic                o_last_frame;

    stepper_can_command_framer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_func           (i_func),
        .i_enable_flag    (i_enable_flag),
        .i_sync_flag      (i_sync_flag),
        .i_speed_rpm      (i_speed_rpm),
        .i_reverse        (i_reverse),
        .i_acceleration   (i_acceleration),
        .i_pulse_count    (i_pulse_count),
        .i_mode_code      (i_mode_code),
        .i_parameter_code (i_parameter_code),
        .i_period_ms      (i_period_ms),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_can_id         (o_can_id),
        .o_frame_length   (o_frame_length),
        .o_bytes_low      (o_bytes_low),
        .o_bytes_high     (o_bytes_high),
        .o_rejected       (o_rejected),
        .o_last_frame     (o_last_frame)
    );

    // The testbench's own copy of the configuration registers. It is updated at the
    // edge that accepts a write, so every command predicted after it sees the new value.
    logic [7:0]  motor_addr  = ADDR_RST;
    logic [7:0]  check_byte  = CHECK_RST;
    logic [15:0] speed_limit = MAXSPD_RST;

    // Frames still owed by the block, oldest first.
    frame_t expected_frames[$];
    int     mismatches = 0;
    int     cycles     = 0;

    directed_row_t directed_table[$];

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a run that hangs on a handshake ends here as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Builds the command bytes for one command under the current configuration and
    // cuts them into frames, appending each frame to the expected queue. Byte 0 of every
    // frame repeats the first command byte; the rest carry up to FRAME_PAYLOAD bytes each.
    function automatic void predict_frames(input command_t c);
        logic [7:0]  msg [0:15];
        logic [7:0]  addr;
        logic [15:0] spd;
        logic [31:0] mag;
        logic [63:0] data;
        logic [7:0]  pkt;
        logic        bad;
        int unsigned n;
        int unsigned pos;
        int unsigned chunk;
        frame_t      fr;
        for (int i = 0; i < 16; i++) msg[i] = 8'h00;
        bad  = 1'b0;
        n    = 0;
        addr = motor_addr;
        spd  = (c.spd > speed_limit) ? speed_limit : c.spd;
        case (c.func)
            FN_ENABLE: begin
                msg[0] = OP_ENABLE; msg[1] = SUB_ENABLE;
                msg[2] = {7'd0, c.en}; msg[3] = {7'd0, c.sy}; n = 4;
            end
            FN_SPEED: begin
                // The direction byte follows the input even when the limit is zero.
                msg[0] = OP_SPEED; msg[1] = {7'd0, c.rev}; msg[2] = spd[15:8];
                msg[3] = spd[7:0]; msg[4] = c.acc; msg[5] = {7'd0, c.sy}; n = 6;
            end
            FN_POSITION: begin
                if (c.mode > POS_MODE_MAX) begin
                    bad = 1'b1;
                end else begin
                    // Sign byte plus magnitude; the most negative count keeps its pattern.
                    mag = c.pul[31] ? (32'd0 - c.pul) : c.pul;
                    msg[0] = OP_POSITION; msg[1] = {7'd0, c.pul[31]};
                    msg[2] = spd[15:8]; msg[3] = spd[7:0]; msg[4] = c.acc;
                    msg[5] = mag[31:24]; msg[6] = mag[23:16];
                    msg[7] = mag[15:8]; msg[8] = mag[7:0];
                    msg[9] = c.mode; msg[10] = {7'd0, c.sy}; n = 11;
                end
            end
            FN_QUICK_SETUP: begin
                if (c.mode > POS_MODE_MAX) begin
                    bad = 1'b1;
                end else begin
                    msg[0] = OP_QUICK_SETUP; msg[1] = spd[15:8]; msg[2] = spd[7:0];
                    msg[3] = c.acc; msg[4] = c.mode; msg[5] = {7'd0, c.sy}; n = 6;
                end
            end
            FN_QUICK_MOVE: begin
                // Raw two's-complement pattern, no sign split here.
                msg[0] = OP_QUICK_MOVE; msg[1] = c.pul[31:24]; msg[2] = c.pul[23:16];
                msg[3] = c.pul[15:8]; msg[4] = c.pul[7:0]; n = 5;
            end
            FN_STOP: begin
                msg[0] = OP_STOP; msg[1] = SUB_STOP; msg[2] = {7'd0, c.sy}; n = 3;
            end
            FN_HOME: begin
                if (c.mode > HOME_MODE_MAX) begin
                    bad = 1'b1;
                end else begin
                    msg[0] = OP_HOME; msg[1] = c.mode; msg[2] = {7'd0, c.sy}; n = 3;
                end
            end
            FN_ABORT_HOME: begin
                msg[0] = OP_ABORT_HOME; msg[1] = SUB_ABORT_HOME; n = 2;
            end
            FN_ORIGIN: begin
                msg[0] = OP_ORIGIN; msg[1] = SUB_ORIGIN; msg[2] = {7'd0, c.en}; n = 3;
            end
            FN_ZERO: begin
                msg[0] = OP_ZERO; msg[1] = SUB_ZERO; n = 2;
            end
            FN_CLEAR_FAULT: begin
                msg[0] = OP_CLEAR_FAULT; msg[1] = SUB_CLEAR_FAULT; n = 2;
            end
            FN_SYNC: begin
                // Broadcast: address zero whatever the register holds.
                msg[0] = OP_SYNC; msg[1] = SUB_SYNC; n = 2; addr = 8'h00;
            end
            FN_READ_PARAM: begin
                msg[0] = c.par; n = 1;
            end
            FN_AUTO_RETURN: begin
                msg[0] = OP_AUTO_RETURN; msg[1] = SUB_AUTO_RETURN; msg[2] = c.par;
                msg[3] = c.per[15:8]; msg[4] = c.per[7:0]; n = 5;
            end
            default: bad = 1'b1;
        endcase

        if (bad) begin
            expected_frames.push_back(REJECT_FRAME);
            return;
        end
        msg[n] = check_byte;
        n++;

        pos = 1;
        pkt = 8'd0;
        while (pos < n && pkt < FRAME_CAP) begin
            chunk = n - pos;
            if (chunk > FRAME_PAYLOAD) chunk = FRAME_PAYLOAD;
            data = '0;
            data[7:0] = msg[0];
            for (int unsigned i = 0; i < chunk; i++) data[8*(i+1) +: 8] = msg[pos+i];
            fr.id   = {addr, pkt};
            fr.len  = 4'(chunk + 1);
            fr.lo   = data[31:0];
            fr.hi   = data[63:32];
            fr.rej  = 1'b0;
            fr.last = (pos + chunk >= n) || (pkt == FRAME_CAP - 1);
            expected_frames.push_back(fr);
            pos += chunk;
            pkt++;
        end
    endfunction

    function automatic command_t mk(input logic [3:0] func, input logic en, input logic sy,
                                    input logic [15:0] spd, input logic rev,
                                    input logic [7:0] acc, input logic [31:0] pul,
                                    input logic [7:0] mode, input logic [7:0] par,
                                    input logic [15:0] per);
        mk = '{func, en, sy, spd, rev, acc, pul, mode, par, per};
    endfunction

    // Random command. Most picks are valid codes with modes near the legal edge, with
    // extra weight on the two-frame position command; the rest are wild modes and the
    // two reserved codes.
    function automatic command_t random_command();
        command_t c;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        c.func = (pick < 16) ? 4'(pick) : FN_POSITION;
        c.en   = 1'($urandom_range(0, 1));
        c.sy   = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       c.spd = 16'hFFFF;
            1:       c.spd = 16'($urandom_range(0, 5000));
            2:       c.spd = speed_limit + 16'($urandom_range(0, 2)) - 16'd1;
            default: c.spd = 16'($urandom_range(0, 65535));
        endcase
        c.rev = 1'($urandom_range(0, 1));
        c.acc = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       c.pul = 32'h8000_0000;
            1:       c.pul = 32'd0 - 32'($urandom_range(0, 1000));
            default: c.pul = $urandom;
        endcase
        c.mode = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 4));
        c.par  = 8'($urandom_range(0, 255));
        c.per  = 16'($urandom_range(0, 65535));
        return c;
    endfunction

    // Puts one command on the inputs and holds it until the block takes it. The start
    // line stays high on return; the next call or an idle burst decides what follows.
    task automatic send_command(input command_t c);
        @(negedge i_clk);
        i_start          = 1'b1;
        i_func           = c.func;
        i_enable_flag    = c.en;
        i_sync_flag      = c.sy;
        i_speed_rpm      = c.spd;
        i_reverse        = c.rev;
        i_acceleration   = c.acc;
        i_pulse_count    = c.pul;
        i_mode_code      = c.mode;
        i_parameter_code = c.par;
        i_period_ms      = c.per;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic idle_burst(input int unsigned n);
        @(negedge i_clk);
        i_start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Stops sending and waits until every owed word has come out. Every command leaves
    // at least one word, so an empty queue means the block is idle.
    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_ADDR:   motor_addr  = value[7:0];
            CFG_CHECK:  check_byte  = value[7:0];
            CFG_MAXSPD: speed_limit = value;
            default:    ;
        endcase
    endtask

    // Writes all three registers; only called with the block drained.
    task automatic configure(input logic [7:0] addr, input logic [7:0] check,
                             input logic [15:0] limit);
        write_register(CFG_ADDR, {8'h00, addr});
        write_register(CFG_CHECK, {8'h00, check});
        write_register(CFG_MAXSPD, limit);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side. A word is on the ports for exactly one cycle and cannot be held off,
    // so it is compared at the edge that ends that cycle.
    always @(posedge i_clk) begin : result_monitor
        frame_t want;
        if (i_rst_n && o_valid) begin
            if (expected_frames.size() == 0) begin
                $error("unexpected word: id 0x%0h length %0d", o_can_id, o_frame_length);
                mismatches++;
            end else begin
                want = expected_frames.pop_front();
                check_field("can_id", want.id, o_can_id);
                check_field("frame_length", want.len, o_frame_length);
                check_field("bytes_low", want.lo, o_bytes_low);
                check_field("bytes_high", want.hi, o_bytes_high);
                check_field("rejected", want.rej, o_rejected);
                check_field("last_frame", want.last, o_last_frame);
            end
        end
    end

    initial begin : stimulus
        command_t    c;
        logic [15:0] limit;
        int unsigned idle_odds;

        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_func           = FN_ENABLE;
        i_enable_flag    = 1'b0;
        i_sync_flag      = 1'b0;
        i_speed_rpm      = '0;
        i_reverse        = 1'b0;
        i_acceleration   = '0;
        i_pulse_count    = '0;
        i_mode_code      = '0;
        i_parameter_code = '0;
        i_period_ms      = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_ADDR;
        i_cfg_data       = '0;

        // Directed table, run with the reset configuration (address 1, check byte 0x6B,
        // limit 5000). Hand-typed frames cover the short fixed commands and every way a
        // command can be rejected; the rest go through the predictor.
        directed_table = '{
            '{mk(FN_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              '{16'h0100, 4'd3, 32'h006B_6D0A, 32'h0, 1'b0, 1'b1}},
            '{mk(FN_SYNC, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              '{16'h0000, 4'd3, 32'h006B_66FF, 32'h0, 1'b0, 1'b1}},
            '{mk(FN_ABORT_HOME, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              '{16'h0100, 4'd3, 32'h006B_489C, 32'h0, 1'b0, 1'b1}},
            '{mk(FN_CLEAR_FAULT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              '{16'h0100, 4'd3, 32'h006B_520E, 32'h0, 1'b0, 1'b1}},
            '{mk(FN_READ_PARAM, 0, 0, 0, 0, 0, 0, 0, 8'hFF, 0), 1'b1,
              '{16'h0100, 4'd2, 32'h0000_6BFF, 32'h0, 1'b0, 1'b1}},
            '{mk(FN_READ_PARAM, 1, 1, 0, 1, 0, 0, 0, 8'h00, 0), 1'b1,
              '{16'h0100, 4'd2, 32'h0000_6B00, 32'h0, 1'b0, 1'b1}},
            '{mk(FN_POSITION, 0, 0, 100, 0, 5, 32'd10, 8'd3, 0, 0), 1'b1, REJECT_FRAME},
            '{mk(FN_QUICK_SETUP, 0, 0, 100, 0, 5, 0, 8'd255, 0, 0), 1'b1, REJECT_FRAME},
            '{mk(FN_HOME, 0, 1, 0, 0, 0, 0, 8'd4, 0, 0), 1'b1, REJECT_FRAME},
            '{mk(FN_RESERVED_LO, 1, 1, 16'hFFFF, 1, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
                 16'hFFFF), 1'b1, REJECT_FRAME},
            '{mk(FN_RESERVED_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, REJECT_FRAME},
            '{mk(FN_ENABLE, 1, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_FRAME},
            '{mk(FN_ENABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_FRAME},
            '{mk(FN_SPEED, 0, 1, 16'hFFFF, 1, 8'hFF, 0, 0, 0, 0), 1'b0, NO_FRAME},
            '{mk(FN_SPEED, 0, 0, 16'd0, 0, 8'h00, 0, 0, 0, 0), 1'b0, NO_FRAME},
            '{mk(FN_POSITION, 0, 1, 16'hFFFF, 0, 8'hFF, 32'h8000_0000, 8'd2, 0, 0),
              1'b0, NO_FRAME},
            '{mk(FN_POSITION, 0, 0, 16'd5000, 0, 8'h00, 32'h7FFF_FFFF, 8'd0, 0, 0),
              1'b0, NO_FRAME},
            '{mk(FN_POSITION, 0, 0, 16'd1, 0, 8'h10, 32'hFFFF_FFFF, 8'd1, 0, 0),
              1'b0, NO_FRAME},
            '{mk(FN_QUICK_SETUP, 0, 1, 16'd4999, 0, 8'h80, 0, 8'd2, 0, 0), 1'b0, NO_FRAME},
            '{mk(FN_QUICK_MOVE, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0), 1'b0, NO_FRAME},
            '{mk(FN_QUICK_MOVE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0), 1'b0, NO_FRAME},
            '{mk(FN_STOP, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_FRAME},
            '{mk(FN_HOME, 0, 1, 0, 0, 0, 0, 8'd3, 0, 0), 1'b0, NO_FRAME},
            '{mk(FN_ORIGIN, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_FRAME},
            '{mk(FN_AUTO_RETURN, 0, 0, 0, 0, 0, 0, 0, 8'hAB, 16'hFFFF), 1'b0, NO_FRAME},
            '{mk(FN_AUTO_RETURN, 0, 0, 0, 0, 0, 0, 0, 8'h01, 16'h0000), 1'b0, NO_FRAME}
        };

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_table[i]) begin
            send_command(directed_table[i].cmd);
            if (directed_table[i].golden) expected_frames.push_back(directed_table[i].want);
            else predict_frames(directed_table[i].cmd);
            if ($urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 3));
        end

        // Random phases, each under its own register setting. The first two take the
        // extremes: highest address with a zero check byte and a zero speed limit, then
        // the lowest address with all-ones check byte and the widest limit.
        for (int ph = 1; ph <= PHASES; ph++) begin
            drain();
            case (ph)
                1:       configure(8'd255, 8'd0, 16'd0);
                2:       configure(8'd1, 8'd255, 16'hFFFF);
                default: begin
                    limit = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                                        : 16'($urandom_range(0, 8000));
                    configure(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), limit);
                end
            endcase

            // Phase three runs back to back; the last phase has no gaps at all.
            idle_odds = (ph == 3 || ph == PHASES) ? 0 : 3;
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                c = random_command();
                send_command(c);
                predict_frames(c);
                // Once, hold the sender back until the block has emptied out.
                if (ph == 4 && k == WORDS_PER_PHASE / 2) drain();
                else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0)
                    idle_burst($urandom_range(1, 3));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_frames.size() != 0) begin
            $error("%0d expected words never arrived", expected_frames.size());
            mismatches += expected_frames.size();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
